[rtl/rmsd_pkg.sv]
// Shared types, constants and field widths for the LED matrix scan driver.
// No dependencies; every other file of the block refers to this package.
package rmsd_pkg;

  // Field widths fixed by the item format.
  localparam int ROW_W    = 5;
  localparam int COL_W    = 5;
  localparam int RGB_W    = 3;
  localparam int RADDR_W  = 4;
  localparam int SETTLE_W = 16;

  // Default geometry of the panel.
  localparam int COLUMNS_DEF    = 32;
  localparam int SCAN_ZONES_DEF = 16;

  // Reset value of the settle register.
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1000;

  // Request codes.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [1:0] {
    PH_SETTLE,
    PH_SHIFT,
    PH_LATCH_HI,
    PH_LATCH_LO
  } phase_t;

  // Pin levels of one tick, minus the colors, which come from the frame store.
  typedef struct packed {
    logic [RADDR_W-1:0] row_addr;
    logic               shift_clk;
    logic               latch;
    logic               out_enable_n;
    logic               frame_end;
    logic               show_rgb;
  } pins_t;

endpackage

[rtl/rmsd_in_if.sv]
// Input channel of the scan driver: valid/ready handshake plus request payload.
// Depends on rmsd_pkg for field widths.
interface rmsd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rmsd_pkg::ROW_W-1:0]  pixel_row;
  logic [rmsd_pkg::COL_W-1:0]  pixel_col;
  logic [rmsd_pkg::RGB_W-1:0]  pixel_color;

  modport source (output valid, req_type, pixel_row, pixel_col, pixel_color, input ready);
  modport sink   (input valid, req_type, pixel_row, pixel_col, pixel_color, output ready);
endinterface

[rtl/rmsd_out_if.sv]
// Result channel of the scan driver: valid/ready handshake plus the pin vector.
// Depends on rmsd_pkg for field widths.
interface rmsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [rmsd_pkg::RADDR_W-1:0]  row_addr;
  logic [rmsd_pkg::RGB_W-1:0]    upper_rgb;
  logic [rmsd_pkg::RGB_W-1:0]    lower_rgb;
  logic                          shift_clk;
  logic                          latch;
  logic                          out_enable_n;
  logic                          frame_end;

  modport source (output valid, row_addr, upper_rgb, lower_rgb, shift_clk, latch,
                  out_enable_n, frame_end, input ready);
  modport sink   (input valid, row_addr, upper_rgb, lower_rgb, shift_clk, latch,
                  out_enable_n, frame_end, output ready);
endinterface

[rtl/rmsd_seq.sv]
// Refresh sequencer: zone, phase, column and settle counters plus the settle register.
// Depends on rmsd_pkg for the phase enum and the pin struct.
module rmsd_seq #(
  parameter int COLUMNS    = rmsd_pkg::COLUMNS_DEF,
  parameter int SCAN_ZONES = rmsd_pkg::SCAN_ZONES_DEF,
  localparam int ZW = $clog2(SCAN_ZONES),
  localparam int CW = $clog2(COLUMNS)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rmsd_pkg::SETTLE_W-1:0]  cfg_wdata,
  input  logic                           tick,
  output rmsd_pkg::pins_t                pins,
  output logic [ZW-1:0]                  rd_zone,
  output logic [CW-1:0]                  rd_col
);

  rmsd_pkg::phase_t               phase_r, phase_nxt;
  logic [ZW-1:0]                  zone_r, zone_nxt;
  logic [CW-1:0]                  col_r, col_nxt;
  logic                           half_r, half_nxt;
  logic [rmsd_pkg::SETTLE_W-1:0]  cnt_r, cnt_nxt;
  logic [rmsd_pkg::SETTLE_W-1:0]  ticks_r;
  logic [rmsd_pkg::SETTLE_W-1:0]  limit;
  logic [rmsd_pkg::SETTLE_W:0]    cnt_inc;
  logic                           col_last;
  logic                           zone_last;
  logic [7:0]                     zone_ext;

  // A zero setting behaves as one tick.
  assign limit     = (ticks_r == '0) ? rmsd_pkg::SETTLE_W'(1) : ticks_r;
  assign cnt_inc   = {1'b0, cnt_r} + (rmsd_pkg::SETTLE_W + 1)'(1);
  assign col_last  = (col_r == CW'(COLUMNS - 1));
  assign zone_last = (zone_r == ZW'(SCAN_ZONES - 1));

  always_comb begin
    phase_nxt = phase_r;
    zone_nxt  = zone_r;
    col_nxt   = col_r;
    half_nxt  = half_r;
    cnt_nxt   = cnt_r;
    if (tick) begin
      case (phase_r)
        rmsd_pkg::PH_SETTLE: begin
          if (cnt_inc >= {1'b0, limit}) begin
            cnt_nxt   = '0;
            phase_nxt = rmsd_pkg::PH_SHIFT;
            col_nxt   = '0;
            half_nxt  = 1'b0;
          end else begin
            cnt_nxt = cnt_inc[rmsd_pkg::SETTLE_W-1:0];
          end
        end
        rmsd_pkg::PH_SHIFT: begin
          if (!half_r) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            if (col_last) begin
              col_nxt   = '0;
              phase_nxt = rmsd_pkg::PH_LATCH_HI;
            end else begin
              col_nxt = col_r + CW'(1);
            end
          end
        end
        rmsd_pkg::PH_LATCH_HI: begin
          phase_nxt = rmsd_pkg::PH_LATCH_LO;
        end
        rmsd_pkg::PH_LATCH_LO: begin
          zone_nxt  = zone_last ? '0 : zone_r + ZW'(1);
          phase_nxt = rmsd_pkg::PH_SETTLE;
          cnt_nxt   = '0;
        end
        default: begin
          phase_nxt = rmsd_pkg::PH_SETTLE;
        end
      endcase
    end
  end

  assign zone_ext = 8'(zone_r);

  always_comb begin
    pins              = '0;
    pins.row_addr     = zone_ext[rmsd_pkg::RADDR_W-1:0];
    case (phase_r)
      rmsd_pkg::PH_SETTLE: begin
        pins.show_rgb = 1'b0;
      end
      rmsd_pkg::PH_SHIFT: begin
        pins.show_rgb  = 1'b1;
        pins.shift_clk = half_r;
      end
      rmsd_pkg::PH_LATCH_HI: begin
        pins.latch = 1'b1;
      end
      rmsd_pkg::PH_LATCH_LO: begin
        pins.out_enable_n = 1'b1;
        pins.frame_end    = zone_last;
      end
      default: begin
        pins.show_rgb = 1'b0;
      end
    endcase
  end

  assign rd_zone = zone_r;
  assign rd_col  = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rmsd_pkg::PH_SETTLE;
      zone_r  <= '0;
      col_r   <= '0;
      half_r  <= 1'b0;
      cnt_r   <= '0;
      ticks_r <= rmsd_pkg::SETTLE_RESET;
    end else begin
      phase_r <= phase_nxt;
      zone_r  <= zone_nxt;
      col_r   <= col_nxt;
      half_r  <= half_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        ticks_r <= cfg_wdata;
      end
    end
  end

endmodule

[rtl/rmsd_fbuf.sv]
// Frame store: upper and lower half banks addressed by zone and column, with a
// clearing sweep after reset. Depends on rmsd_pkg for field widths.
module rmsd_fbuf #(
  parameter int COLUMNS    = rmsd_pkg::COLUMNS_DEF,
  parameter int SCAN_ZONES = rmsd_pkg::SCAN_ZONES_DEF,
  localparam int ZW = $clog2(SCAN_ZONES),
  localparam int CW = $clog2(COLUMNS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [rmsd_pkg::ROW_W-1:0]   wr_row,
  input  logic [rmsd_pkg::COL_W-1:0]   wr_col,
  input  logic [rmsd_pkg::RGB_W-1:0]   wr_color,
  input  logic                         rd_en,
  input  logic [ZW-1:0]                rd_zone,
  input  logic [CW-1:0]                rd_col,
  output logic [rmsd_pkg::RGB_W-1:0]   rd_upper,
  output logic [rmsd_pkg::RGB_W-1:0]   rd_lower,
  output logic                         clearing
);

  localparam int AW    = ZW + CW;
  localparam int DEPTH = 1 << AW;

  logic [rmsd_pkg::RGB_W-1:0] mem_up [DEPTH];
  logic [rmsd_pkg::RGB_W-1:0] mem_lo [DEPTH];
  logic [rmsd_pkg::RGB_W-1:0] rd_upper_r;
  logic [rmsd_pkg::RGB_W-1:0] rd_lower_r;
  logic                       clearing_r;
  logic [AW-1:0]              clr_addr_r;

  logic [6:0]    row_ext;
  logic [6:0]    row_off;
  logic [7:0]    col_ext;
  logic          in_range;
  logic          to_lower;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign row_ext  = 7'(wr_row);
  assign col_ext  = 8'(wr_col);
  assign in_range = (row_ext < 7'(2 * SCAN_ZONES)) && (col_ext < 8'(COLUMNS));
  assign to_lower = (row_ext >= 7'(SCAN_ZONES));
  assign row_off  = to_lower ? row_ext - 7'(SCAN_ZONES) : row_ext;
  assign waddr    = {row_off[ZW-1:0], col_ext[CW-1:0]};
  assign raddr    = {rd_zone, rd_col};

  // Both banks are zeroed one address per cycle while the sweep runs.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem_up[clr_addr_r] <= '0;
    end else if (wr_en && in_range && !to_lower) begin
      mem_up[waddr] <= wr_color;
    end
    if (rd_en) begin
      rd_upper_r <= mem_up[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem_lo[clr_addr_r] <= '0;
    end else if (wr_en && in_range && to_lower) begin
      mem_lo[waddr] <= wr_color;
    end
    if (rd_en) begin
      rd_lower_r <= mem_lo[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;
  assign clearing = clearing_r;

endmodule

[rtl/rgb_matrix_scan_driver_unit.sv]
// Top level of the LED matrix scan driver: sequencer, frame store and result pipeline.
// Depends on rmsd_pkg, rmsd_in_if, rmsd_out_if, rmsd_seq and rmsd_fbuf.
//
//   channel | direction | handshake          | contents
//   --------+-----------+--------------------+---------------------------------------
//   in_ch   | in        | valid / ready      | req_type, pixel_row, pixel_col, color
//   out_ch  | out       | valid / ready      | one pin vector per scan tick
//   cfg_*   | in        | cfg_we, no ready   | settle_ticks
//
// One item is accepted per cycle while in_ch.ready is high; a scan-tick item's pin
// vector moves via stage one and the registered store read into the output register.
// Pixel-write items update the store at acceptance and yield no result.
// After reset, in_ch.ready stays low for the store clearing sweep, which zeroes all
// 2**(clog2(SCAN_ZONES) + clog2(COLUMNS)) bank addresses (512 for a 32 by 32 panel).
// A stall on out_ch backs up through the two result stages into in_ch.ready.
module rgb_matrix_scan_driver_unit #(
  parameter int COLUMNS    = rmsd_pkg::COLUMNS_DEF,
  parameter int SCAN_ZONES = rmsd_pkg::SCAN_ZONES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rmsd_in_if.sink                        in_ch,
  rmsd_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rmsd_pkg::SETTLE_W-1:0]  cfg_wdata
);

  localparam int ZW = $clog2(SCAN_ZONES);
  localparam int CW = $clog2(COLUMNS);

  logic                        accept;
  logic                        tick;
  logic                        pix_wr;
  logic                        clearing;
  rmsd_pkg::pins_t             seq_pins;
  logic [ZW-1:0]               rd_zone;
  logic [CW-1:0]               rd_col;
  logic [rmsd_pkg::RGB_W-1:0]  rd_upper;
  logic [rmsd_pkg::RGB_W-1:0]  rd_lower;

  // Stage one holds the pin levels while the store read completes; stage two is
  // the result register seen on out_ch.
  logic                        s1_valid_r, s1_valid_nxt;
  rmsd_pkg::pins_t             s1_pins_r;
  logic                        s2_valid_r, s2_valid_nxt;
  rmsd_pkg::pins_t             s2_pins_r;
  logic [rmsd_pkg::RGB_W-1:0]  s2_upper_r;
  logic [rmsd_pkg::RGB_W-1:0]  s2_lower_r;
  logic                        s2_free;
  logic                        s1_move;

  assign s2_free     = !s2_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && s2_free;
  assign in_ch.ready = !clearing && (!s1_valid_r || s2_free);
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick        = accept && (in_ch.req_type == rmsd_pkg::REQ_TICK);
  assign pix_wr      = accept && (in_ch.req_type == rmsd_pkg::REQ_PIXEL);

  rmsd_seq #(
    .COLUMNS    (COLUMNS),
    .SCAN_ZONES (SCAN_ZONES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tick      (tick),
    .pins      (seq_pins),
    .rd_zone   (rd_zone),
    .rd_col    (rd_col)
  );

  // The read for a tick is launched at its acceptance and held while stage one
  // waits, since the read enable is the tick itself.
  rmsd_fbuf #(
    .COLUMNS    (COLUMNS),
    .SCAN_ZONES (SCAN_ZONES)
  ) u_fbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (pix_wr),
    .wr_row   (in_ch.pixel_row),
    .wr_col   (in_ch.pixel_col),
    .wr_color (in_ch.pixel_color),
    .rd_en    (tick),
    .rd_zone  (rd_zone),
    .rd_col   (rd_col),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower),
    .clearing (clearing)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (tick) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s1_move) begin
      s2_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Colors are forced to black outside the shift phase.
  always_ff @(posedge clk) begin
    if (tick) begin
      s1_pins_r <= seq_pins;
    end
    if (s1_move) begin
      s2_pins_r  <= s1_pins_r;
      s2_upper_r <= s1_pins_r.show_rgb ? rd_upper : '0;
      s2_lower_r <= s1_pins_r.show_rgb ? rd_lower : '0;
    end
  end

  assign out_ch.valid        = s2_valid_r;
  assign out_ch.row_addr     = s2_pins_r.row_addr;
  assign out_ch.upper_rgb    = s2_upper_r;
  assign out_ch.lower_rgb    = s2_lower_r;
  assign out_ch.shift_clk    = s2_pins_r.shift_clk;
  assign out_ch.latch        = s2_pins_r.latch;
  assign out_ch.out_enable_n = s2_pins_r.out_enable_n;
  assign out_ch.frame_end    = s2_pins_r.frame_end;

endmodule

[rtl/rmsd_checker.sv]
// Port-level checks for the scan driver, attached to the top level by bind.
// Depends on rmsd_pkg for field widths and on rgb_matrix_scan_driver_unit.
module rmsd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rmsd_pkg::RADDR_W-1:0]  row_addr,
  input logic [rmsd_pkg::RGB_W-1:0]    upper_rgb,
  input logic [rmsd_pkg::RGB_W-1:0]    lower_rgb,
  input logic                          shift_clk,
  input logic                          latch,
  input logic                          out_enable_n,
  input logic                          frame_end
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({row_addr, upper_rgb, lower_rgb, shift_clk,
                                          latch, out_enable_n, frame_end}))
    else $error("result payload changed while stalled");

  a_quiet_outside_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (latch || out_enable_n) |->
      !shift_clk && upper_rgb == '0 && lower_rgb == '0 && !(latch && out_enable_n))
    else $error("colors or clock active during a latch tick");

  a_frame_end_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> out_enable_n && !latch)
    else $error("frame end outside the blanking tick");

endmodule

bind rgb_matrix_scan_driver_unit rmsd_checker u_rmsd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .row_addr     (out_ch.row_addr),
  .upper_rgb    (out_ch.upper_rgb),
  .lower_rgb    (out_ch.lower_rgb),
  .shift_clk    (out_ch.shift_clk),
  .latch        (out_ch.latch),
  .out_enable_n (out_ch.out_enable_n),
  .frame_end    (out_ch.frame_end)
);
